@@ sv/sexp_tok_pkg.sv @@
// ----------------------------------------------------------------------------
// sexp_tok_pkg
// Token kinds and the result item type shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package sexp_tok_pkg;

    localparam logic [3:0] KIND_LPAREN   = 4'd0;
    localparam logic [3:0] KIND_LBRACKET = 4'd1;
    localparam logic [3:0] KIND_RPAREN   = 4'd2;
    localparam logic [3:0] KIND_RBRACKET = 4'd3;
    localparam logic [3:0] KIND_QUOTE    = 4'd4;
    localparam logic [3:0] KIND_STRING   = 4'd5;
    localparam logic [3:0] KIND_SYMBOL   = 4'd6;
    localparam logic [3:0] KIND_NUMBER   = 4'd7;
    localparam logic [3:0] KIND_CHAR     = 4'd8;
    localparam logic [3:0] KIND_HASH     = 4'd9;

    typedef struct packed {
        logic [3:0]  kind;
        logic        has_byte;
        logic [7:0]  text_byte;
        logic [31:0] number_value;
        logic        is_last;
    } tok_t;

    localparam tok_t TOK_NONE = '{kind: KIND_LPAREN, has_byte: 1'b0, text_byte: 8'd0,
                                  number_value: 32'd0, is_last: 1'b0};

endpackage

@@ sv/sexp_tok_core.sv @@
// ----------------------------------------------------------------------------
// sexp_tok_core
// Lexer state and the single-pass step logic; emits up to two tokens per item.
// ----------------------------------------------------------------------------
module sexp_tok_core
    import sexp_tok_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] byte_value,
    input  logic       end_of_input,
    output logic       res0_valid,
    output tok_t       res0,
    output logic       res1_valid,
    output tok_t       res1
);

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_STRING  = 3'd1;
    localparam logic [2:0] MODE_COMMENT = 3'd2;
    localparam logic [2:0] MODE_SYMBOL  = 3'd3;
    localparam logic [2:0] MODE_DECIMAL = 3'd4;
    localparam logic [2:0] MODE_HASH    = 3'd5;
    localparam logic [2:0] MODE_HEX     = 3'd6;
    localparam logic [2:0] MODE_CHAR    = 3'd7;

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        emit;
        tok_t        tok;
        logic [2:0]  mode;
        logic [31:0] acc;
        logic        stop;
    } idle_t;

    logic [2:0]  mode_reg, mode_next;
    logic [31:0] acc_reg, acc_next;
    logic        stop_reg, stop_next;

    function automatic logic is_dec(input logic [7:0] c);
        is_dec = (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_hexletter(input logic [7:0] c);
        is_hexletter = ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    function automatic logic sym_start(input logic [7:0] c);
        sym_start = is_alpha(c) || (c == "+") || (c == "-") || (c == "/") ||
                    (c == "*") || (c == "=") || (c == ">") || (c == "<");
    endfunction

    function automatic logic sym_cont(input logic [7:0] c);
        sym_cont = sym_start(c) || is_dec(c) || (c == "_") || (c == "?");
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (is_dec(c))
            t = c - 8'h30;
        else if ((c >= "a") && (c <= "f"))
            t = c - 8'h57;
        else
            t = c - 8'h37;
        hex_val = t[3:0];
    endfunction

    function automatic tok_t mk_tok(input logic [3:0] kind, input logic has,
                                    input logic [7:0] tb, input logic [31:0] num,
                                    input logic last);
        tok_t t;
        t.kind         = kind;
        t.has_byte     = has;
        t.text_byte    = tb;
        t.number_value = num;
        t.is_last      = last;
        mk_tok = t;
    endfunction

    // Handle a byte as seen from idle, starting from the given accumulator.
    function automatic idle_t idle_byte(input logic [7:0] c, input logic [31:0] acc,
                                        input logic stop);
        idle_t r;
        r.emit = 1'b0;
        r.tok  = TOK_NONE;
        r.mode = MODE_IDLE;
        r.acc  = acc;
        r.stop = stop;
        case (c)
            "(":     begin r.emit = 1'b1; r.tok = mk_tok(KIND_LPAREN, 1'b0, 8'd0, 32'd0, 1'b1); end
            "[":     begin r.emit = 1'b1; r.tok = mk_tok(KIND_LBRACKET, 1'b0, 8'd0, 32'd0, 1'b1); end
            ")":     begin r.emit = 1'b1; r.tok = mk_tok(KIND_RPAREN, 1'b0, 8'd0, 32'd0, 1'b1); end
            "]":     begin r.emit = 1'b1; r.tok = mk_tok(KIND_RBRACKET, 1'b0, 8'd0, 32'd0, 1'b1); end
            8'h27:   begin r.emit = 1'b1; r.tok = mk_tok(KIND_QUOTE, 1'b0, 8'd0, 32'd0, 1'b1); end
            8'h22:   r.mode = MODE_STRING;
            ";":     r.mode = MODE_COMMENT;
            "#":     r.mode = MODE_HASH;
            default:
            begin
                if (sym_start(c))
                begin
                    r.mode = MODE_SYMBOL;
                    r.emit = 1'b1;
                    r.tok  = mk_tok(KIND_SYMBOL, 1'b1, c, 32'd0, 1'b0);
                end
                else if (is_dec(c))
                begin
                    r.mode = MODE_DECIMAL;
                    r.acc  = {28'd0, hex_val(c)};
                    r.stop = 1'b0;
                end
            end
        endcase
        idle_byte = r;
    endfunction

    logic        end_flag;
    logic [35:0] mac10;
    logic [35:0] mac16;
    logic [31:0] acc10;
    logic [31:0] acc16;
    idle_t       idle_here;
    idle_t       idle_after_num;
    idle_t       idle_after_tok;

    assign end_flag = end_of_input || (byte_value == 8'd0);

    // acc*10 + d and acc*16 + d, saturated to 32 bits
    assign mac10 = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) +
                   {32'd0, hex_val(byte_value)};
    assign mac16 = ({4'd0, acc_reg} << 4) + {32'd0, hex_val(byte_value)};
    assign acc10 = (mac10[35:32] != 4'd0) ? SAT32 : mac10[31:0];
    assign acc16 = (mac16[35:32] != 4'd0) ? SAT32 : mac16[31:0];

    assign idle_here      = idle_byte(byte_value, acc_reg, stop_reg);
    assign idle_after_num = idle_byte(byte_value, 32'd0, 1'b0);
    assign idle_after_tok = idle_byte(byte_value, acc_reg, stop_reg);

    always_comb
    begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        stop_next  = stop_reg;
        res0_valid = 1'b0;
        res0       = TOK_NONE;
        res1_valid = 1'b0;
        res1       = TOK_NONE;
        if (end_flag)
        begin
            // close whatever is pending and return to idle
            mode_next = MODE_IDLE;
            acc_next  = 32'd0;
            stop_next = 1'b0;
            case (mode_reg)
                MODE_STRING:  begin res0_valid = 1'b1; res0 = mk_tok(KIND_STRING, 1'b0, 8'd0, 32'd0, 1'b1); end
                MODE_SYMBOL:  begin res0_valid = 1'b1; res0 = mk_tok(KIND_SYMBOL, 1'b0, 8'd0, 32'd0, 1'b1); end
                MODE_DECIMAL,
                MODE_HEX:     begin res0_valid = 1'b1; res0 = mk_tok(KIND_NUMBER, 1'b0, 8'd0, acc_reg, 1'b1); end
                MODE_HASH:    begin res0_valid = 1'b1; res0 = mk_tok(KIND_HASH, 1'b0, 8'd0, 32'd0, 1'b1); end
                MODE_CHAR:    begin res0_valid = 1'b1; res0 = mk_tok(KIND_CHAR, 1'b0, 8'd0, 32'd0, 1'b1); end
                default:      res0_valid = 1'b0;
            endcase
        end
        else
        begin
            case (mode_reg)
                MODE_STRING:
                begin
                    res0_valid = 1'b1;
                    if (byte_value == 8'h22)
                    begin
                        mode_next = MODE_IDLE;
                        res0      = mk_tok(KIND_STRING, 1'b0, 8'd0, 32'd0, 1'b1);
                    end
                    else
                        res0 = mk_tok(KIND_STRING, 1'b1, byte_value, 32'd0, 1'b0);
                end
                MODE_COMMENT:
                begin
                    if (byte_value == 8'h0A)
                        mode_next = MODE_IDLE;
                end
                MODE_SYMBOL:
                begin
                    res0_valid = 1'b1;
                    if (sym_cont(byte_value))
                        res0 = mk_tok(KIND_SYMBOL, 1'b1, byte_value, 32'd0, 1'b0);
                    else
                    begin
                        res0       = mk_tok(KIND_SYMBOL, 1'b0, 8'd0, 32'd0, 1'b1);
                        res1_valid = idle_after_tok.emit;
                        res1       = idle_after_tok.tok;
                        mode_next  = idle_after_tok.mode;
                        acc_next   = idle_after_tok.acc;
                        stop_next  = idle_after_tok.stop;
                    end
                end
                MODE_DECIMAL,
                MODE_HEX:
                begin
                    if (is_dec(byte_value) && (mode_reg == MODE_DECIMAL))
                    begin
                        if (!stop_reg)
                            acc_next = acc10;
                    end
                    else if (is_hexletter(byte_value) && (mode_reg == MODE_DECIMAL))
                        stop_next = 1'b1;
                    else if ((is_dec(byte_value) || is_hexletter(byte_value)) &&
                             (mode_reg == MODE_HEX))
                        acc_next = acc16;
                    else
                    begin
                        // close the number, then treat the byte from idle
                        res0_valid = 1'b1;
                        res0       = mk_tok(KIND_NUMBER, 1'b0, 8'd0, acc_reg, 1'b1);
                        res1_valid = idle_after_num.emit;
                        res1       = idle_after_num.tok;
                        mode_next  = idle_after_num.mode;
                        acc_next   = idle_after_num.acc;
                        stop_next  = idle_after_num.stop;
                    end
                end
                MODE_HASH:
                begin
                    if (byte_value == "x")
                    begin
                        mode_next = MODE_HEX;
                        acc_next  = 32'd0;
                        stop_next = 1'b0;
                    end
                    else if (byte_value == 8'h5C)
                        mode_next = MODE_CHAR;
                    else
                    begin
                        res0_valid = 1'b1;
                        res0       = mk_tok(KIND_HASH, 1'b0, 8'd0, 32'd0, 1'b1);
                        res1_valid = idle_after_tok.emit;
                        res1       = idle_after_tok.tok;
                        mode_next  = idle_after_tok.mode;
                        acc_next   = idle_after_tok.acc;
                        stop_next  = idle_after_tok.stop;
                    end
                end
                MODE_CHAR:
                begin
                    mode_next  = MODE_IDLE;
                    res0_valid = 1'b1;
                    res0       = mk_tok(KIND_CHAR, 1'b1, byte_value, 32'd0, 1'b1);
                end
                default:
                begin
                    res0_valid = idle_here.emit;
                    res0       = idle_here.tok;
                    mode_next  = idle_here.mode;
                    acc_next   = idle_here.acc;
                    stop_next  = idle_here.stop;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= 32'd0;
            stop_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            stop_reg <= stop_next;
        end
    end

endmodule

@@ sv/sexp_tok_fifo.sv @@
// ----------------------------------------------------------------------------
// sexp_tok_fifo
// Four-entry result queue; takes up to two tokens per cycle, gives one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module sexp_tok_fifo
    import sexp_tok_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push0,
    input  tok_t data0,
    input  logic push1,
    input  tok_t data1,
    output logic room2,
    output logic out_valid,
    input  logic out_ready,
    output tok_t out_data
);

    tok_t       mem [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;
    logic [1:0] wr_ptr_plus1;

    assign out_valid    = (count_reg != 3'd0);
    assign out_data     = mem[rd_ptr_reg];
    assign pop          = out_valid && out_ready;
    assign room2        = (count_reg <= 3'd2);
    assign wr_ptr_plus1 = wr_ptr_reg + 2'd1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + {1'b0, push0} + {1'b0, push1};
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {2'd0, push0} + {2'd0, push1} - {2'd0, pop};
    end

    // push1 is only raised together with push0
    always_ff @(posedge clk)
    begin
        if (push0)
            mem[wr_ptr_reg] <= data0;
        if (push1)
            mem[wr_ptr_plus1] <= data1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/s_expression_tokenizer.sv @@
// ----------------------------------------------------------------------------
// s_expression_tokenizer
// Byte-stream s-expression lexer with a stream input and a token stream output.
// ----------------------------------------------------------------------------
// One source byte is taken per item (s_tlast marks end of input, as does a
// zero byte) and lands in an input register. The lexer step then updates its
// state, once the queue has room for two tokens, and writes zero, one or two
// tokens into a four-entry result queue, from which a token reaches the master
// side. A new byte is taken every cycle as long as the queue has room for two
// tokens; the sustained rate is one byte per cycle when each byte yields at
// most one token and m_tready stays high, and is set by the single-token
// output port when a byte both closes a symbol, number or bare hash and starts
// a new token.
module s_expression_tokenizer
    import sexp_tok_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_value[7:0]
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // has_byte[0], text_byte[8:1], number_value[40:9], zero fill
    output logic [3:0]  m_tuser,   // kind[3:0]
    output logic        m_tlast    // is_last
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;
    logic       room2;
    logic       step;
    logic       s_fire;
    logic       res0_valid, res1_valid;
    tok_t       res0, res1;
    tok_t       out_tok;

    assign step          = in_valid_reg && room2;
    assign s_tready      = !in_valid_reg || step;
    assign s_fire        = s_tvalid && s_tready;
    assign in_valid_next = s_fire || (in_valid_reg && !step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    sexp_tok_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .byte_value   (in_byte_reg),
        .end_of_input (in_end_reg),
        .res0_valid   (res0_valid),
        .res0         (res0),
        .res1_valid   (res1_valid),
        .res1         (res1)
    );

    sexp_tok_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push0     (step && res0_valid),
        .data0     (res0),
        .push1     (step && res1_valid),
        .data1     (res1),
        .room2     (room2),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_tok)
    );

    assign m_tdata = {7'd0, out_tok.number_value, out_tok.text_byte, out_tok.has_byte};
    assign m_tuser = out_tok.kind;
    assign m_tlast = out_tok.is_last;

endmodule
